// ----- sv/ubc_pkg.sv -----
// Package for the unary bitmap counter: field widths, command codes,
// microcode step codes, the control-word type and the microprogram ROM.
// Depends on nothing; every other file of the block uses it.
package ubc_pkg;

  localparam int CFG_W   = 6;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 9;
  localparam int UPC_W   = 4;

  localparam logic [CFG_W-1:0]   ACTIVE_RESET = 6'd32;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TEST      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_NEXT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GROW_EVEN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_GROW_ODD  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd6;

  // Microprogram step addresses.
  localparam logic [UPC_W-1:0] UPC_IDLE      = 4'd0;
  localparam logic [UPC_W-1:0] UPC_DISPATCH  = 4'd1;
  localparam logic [UPC_W-1:0] UPC_RD_POS    = 4'd2;
  localparam logic [UPC_W-1:0] UPC_RMW_POS   = 4'd3;
  localparam logic [UPC_W-1:0] UPC_LOAD      = 4'd4;
  localparam logic [UPC_W-1:0] UPC_SCAN_INIT = 4'd5;
  localparam logic [UPC_W-1:0] UPC_SCAN      = 4'd6;
  localparam logic [UPC_W-1:0] UPC_POST      = 4'd7;
  localparam logic [UPC_W-1:0] UPC_RUN_RD    = 4'd8;
  localparam logic [UPC_W-1:0] UPC_RUN_WR    = 4'd9;
  localparam logic [UPC_W-1:0] UPC_EMIT      = 4'd10;

  typedef enum logic [3:0] {
    ACT_WAIT,
    ACT_DISPATCH,
    ACT_RD_POS,
    ACT_RMW_POS,
    ACT_LOAD,
    ACT_SCAN_INIT,
    ACT_SCAN,
    ACT_POST,
    ACT_RUN_RD,
    ACT_RUN_WR,
    ACT_EMIT
  } act_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BRANCH,
    SEQ_DISPATCH
  } seq_e;

  typedef struct packed {
    act_e             act;
    seq_e             seq;
    logic [UPC_W-1:0] next;
    logic [UPC_W-1:0] jump;
  } uword_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  // The microprogram. A branch takes the jump address when the datapath
  // raises its take flag for the current step.
  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      UPC_IDLE:      w = '{ACT_WAIT,      SEQ_BRANCH,   UPC_IDLE,      UPC_DISPATCH};
      UPC_DISPATCH:  w = '{ACT_DISPATCH,  SEQ_DISPATCH, UPC_IDLE,      UPC_IDLE};
      UPC_RD_POS:    w = '{ACT_RD_POS,    SEQ_BRANCH,   UPC_RMW_POS,   UPC_SCAN_INIT};
      UPC_RMW_POS:   w = '{ACT_RMW_POS,   SEQ_NEXT,     UPC_SCAN_INIT, UPC_SCAN_INIT};
      UPC_LOAD:      w = '{ACT_LOAD,      SEQ_NEXT,     UPC_SCAN_INIT, UPC_SCAN_INIT};
      UPC_SCAN_INIT: w = '{ACT_SCAN_INIT, SEQ_BRANCH,   UPC_SCAN,      UPC_POST};
      UPC_SCAN:      w = '{ACT_SCAN,      SEQ_BRANCH,   UPC_SCAN,      UPC_POST};
      UPC_POST:      w = '{ACT_POST,      SEQ_BRANCH,   UPC_EMIT,      UPC_RUN_RD};
      UPC_RUN_RD:    w = '{ACT_RUN_RD,    SEQ_NEXT,     UPC_RUN_WR,    UPC_RUN_WR};
      UPC_RUN_WR:    w = '{ACT_RUN_WR,    SEQ_NEXT,     UPC_SCAN_INIT, UPC_SCAN_INIT};
      UPC_EMIT:      w = '{ACT_EMIT,      SEQ_BRANCH,   UPC_EMIT,      UPC_IDLE};
      default:       w = '{ACT_WAIT,      SEQ_NEXT,     UPC_IDLE,      UPC_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each command's routine.
  function automatic logic [UPC_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
    logic [UPC_W-1:0] entry;
    case (cmd)
      CMD_TEST, CMD_SET, CMD_CLEAR: entry = UPC_RD_POS;
      CMD_LOAD:                     entry = UPC_LOAD;
      default:                      entry = UPC_SCAN_INIT;
    endcase
    return entry;
  endfunction

  function automatic logic [3:0] ones8(input logic [BYTE_W-1:0] b);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      cnt = cnt + 4'(b[i]);
    end
    return cnt;
  endfunction

  // Number of ones from bit 0 up to the first zero.
  function automatic logic [3:0] trailing_ones8(input logic [BYTE_W-1:0] b);
    logic [3:0] cnt;
    logic       run;
    cnt = '0;
    run = 1'b1;
    for (int i = 0; i < BYTE_W; i++) begin
      run = run & b[i];
      cnt = cnt + 4'(run);
    end
    return cnt;
  endfunction

endpackage

// ----- sv/ubc_in_if.sv -----
// Command channel of the unary bitmap counter: valid/ready plus the command word.
// Depends on ubc_pkg for the field widths.
interface ubc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ubc_pkg::CMD_W-1:0]  cmd;
  logic [ubc_pkg::POS_W-1:0]  bit_index;
  logic [ubc_pkg::BYTE_W-1:0] load_value;

  modport source (output valid, cmd, bit_index, load_value, input ready);
  modport sink   (input valid, cmd, bit_index, load_value, output ready);
endinterface

// ----- sv/ubc_out_if.sv -----
// Result channel of the unary bitmap counter: valid/ready plus the result word.
// Depends on ubc_pkg for the field widths.
interface ubc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        bit_value;
  logic [ubc_pkg::COUNT_W-1:0] contiguous_count;
  logic [ubc_pkg::COUNT_W-1:0] total_set;

  modport source (output valid, status, bit_value, contiguous_count, total_set,
                  input ready);
  modport sink   (input valid, status, bit_value, contiguous_count, total_set,
                  output ready);
endinterface

// ----- sv/ubc_store.sv -----
// Byte store of the unary bitmap counter: one write and one registered read
// port, with a valid bit per byte so unwritten bytes read as zero after reset.
// Depends on ubc_pkg.
module ubc_store #(
  parameter int  ARRAY_BYTES = 32,
  localparam int ADDR_W      = (ARRAY_BYTES > 1) ? $clog2(ARRAY_BYTES) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ubc_pkg::store_ctl_t        ctl_i,
  input  logic [ADDR_W-1:0]          rd_addr_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [ubc_pkg::BYTE_W-1:0] wr_data_i,
  output logic [ubc_pkg::BYTE_W-1:0] rd_data_o
);

  logic [ubc_pkg::BYTE_W-1:0] mem [ARRAY_BYTES];
  logic [ARRAY_BYTES-1:0]     vld_q;
  logic [ubc_pkg::BYTE_W-1:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.wr_en) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- sv/unary_bitmap_counter.sv -----
// Unary bitmap counter: a bit array run by a small microprogram that tests,
// sets, clears, extends the run of ones from bit 0, or loads whole bytes.
// Depends on ubc_pkg, ubc_in_if, ubc_out_if and ubc_store.
//
// Usage: one command word enters on in_i and exactly one result word leaves
// on out_o, in command order. Both channels move a word at a rising edge with
// valid and ready high. active_bytes is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. Values above ARRAY_BYTES act as ARRAY_BYTES.
// Every command ends with a scan of the active bytes, one byte per cycle
// through the store's single read port. Each bit that set next or a grow
// sets adds a read-modify-write of that bit's byte and a rescan. One command
// is in flight at a time; ready is high only at the idle step. Reset clears
// the array through per-byte valid bits and sets active_bytes to 32. Stall:
// the sequencer waits at its emit step only while the output register still
// holds an untaken word.
module unary_bitmap_counter #(
  parameter int ARRAY_BYTES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ubc_pkg::CFG_W-1:0] cfg_wdata_i,
  ubc_in_if.sink                    in_i,
  ubc_out_if.source                 out_o
);

  localparam int ADDR_W = (ARRAY_BYTES > 1) ? $clog2(ARRAY_BYTES) : 1;
  localparam int USED_W = $clog2(ARRAY_BYTES + 1);
  localparam int CNT_W  = $clog2(ARRAY_BYTES * 8 + 1);

  // Sequencer state.
  logic [ubc_pkg::UPC_W-1:0] upc_q, upc_d;
  ubc_pkg::uword_t           uw;
  logic                      take;

  // Configuration.
  logic [ubc_pkg::CFG_W-1:0] active_q;
  logic [USED_W-1:0]         used;
  logic [31:0]               bits_used;

  // Command word held for the duration of the routine.
  logic [ubc_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [ubc_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [ubc_pkg::BYTE_W-1:0] load_q, load_d;

  // Datapath registers.
  logic              status_q, status_d;
  logic              bitv_q, bitv_d;
  logic              pass_q, pass_d;
  logic              open_q, open_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [USED_W-1:0] rd_addr_q, rd_addr_d;

  // Output register.
  logic                        ovalid_q, ovalid_d;
  logic                        ostat_q, ostat_d;
  logic                        obitv_q, obitv_d;
  logic [ubc_pkg::COUNT_W-1:0] orun_q, orun_d;
  logic [ubc_pkg::COUNT_W-1:0] otot_q, otot_d;

  // Store port.
  ubc_pkg::store_ctl_t        store_ctl;
  logic [ADDR_W-1:0]          st_rd_addr, st_wr_addr;
  logic [ubc_pkg::BYTE_W-1:0] st_wr_data, st_rd_data;

  logic bit_ok, byte_ok, run_ok, grow, want_odd, need_set;

  ubc_store #(
    .ARRAY_BYTES (ARRAY_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (store_ctl),
    .rd_addr_i (st_rd_addr),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (st_wr_data),
    .rd_data_o (st_rd_data)
  );

  assign uw = ubc_pkg::ucode(upc_q);

  assign used = (32'(active_q) > 32'(ARRAY_BYTES)) ? USED_W'(ARRAY_BYTES)
                                                   : USED_W'(active_q);
  assign bits_used = 32'(used) << 3;

  assign bit_ok  = 32'(pos_q) < bits_used;
  assign byte_ok = 32'(pos_q) < 32'(used);
  assign run_ok  = 32'(run_q) < bits_used;

  assign grow     = (cmd_q == ubc_pkg::CMD_GROW_EVEN) || (cmd_q == ubc_pkg::CMD_GROW_ODD);
  assign want_odd = (cmd_q == ubc_pkg::CMD_GROW_ODD);
  // A grow command keeps setting the next bit while the run has the wrong
  // parity; set next sets it once, on the first pass only.
  assign need_set = grow ? (run_q[0] != want_odd)
                         : ((cmd_q == ubc_pkg::CMD_SET_NEXT) && !pass_q);

  assign in_i.ready = (uw.act == ubc_pkg::ACT_WAIT);

  always_comb begin
    cmd_d      = cmd_q;
    pos_d      = pos_q;
    load_d     = load_q;
    status_d   = status_q;
    bitv_d     = bitv_q;
    pass_d     = pass_q;
    open_d     = open_q;
    run_d      = run_q;
    total_d    = total_q;
    rd_addr_d  = rd_addr_q;
    take       = 1'b0;
    store_ctl  = '0;
    st_rd_addr = '0;
    st_wr_addr = '0;
    st_wr_data = '0;

    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    obitv_d  = obitv_q;
    orun_d   = orun_q;
    otot_d   = otot_q;
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (uw.act)
      ubc_pkg::ACT_WAIT: begin
        take = in_i.valid;
        if (in_i.valid) begin
          cmd_d    = in_i.cmd;
          pos_d    = in_i.bit_index;
          load_d   = in_i.load_value;
          status_d = 1'b0;
          bitv_d   = 1'b0;
          pass_d   = 1'b0;
        end
      end
      ubc_pkg::ACT_DISPATCH: begin
      end
      ubc_pkg::ACT_RD_POS: begin
        if (!bit_ok) begin
          status_d = 1'b1;
          take     = 1'b1;
        end else begin
          store_ctl.rd_en = 1'b1;
          st_rd_addr      = ADDR_W'(pos_q >> 3);
        end
      end
      ubc_pkg::ACT_RMW_POS: begin
        if (cmd_q == ubc_pkg::CMD_TEST) begin
          bitv_d = st_rd_data[pos_q[2:0]];
        end else begin
          store_ctl.wr_en = 1'b1;
          st_wr_addr      = ADDR_W'(pos_q >> 3);
          st_wr_data      = (cmd_q == ubc_pkg::CMD_SET)
                            ? (st_rd_data | (8'b1 << pos_q[2:0]))
                            : (st_rd_data & ~(8'b1 << pos_q[2:0]));
        end
      end
      ubc_pkg::ACT_LOAD: begin
        if (byte_ok) begin
          store_ctl.wr_en = 1'b1;
          st_wr_addr      = ADDR_W'(pos_q);
          st_wr_data      = load_q;
        end else begin
          status_d = 1'b1;
        end
      end
      ubc_pkg::ACT_SCAN_INIT: begin
        run_d   = '0;
        total_d = '0;
        open_d  = 1'b1;
        if (used == '0) begin
          take = 1'b1;
        end else begin
          store_ctl.rd_en = 1'b1;
          st_rd_addr      = '0;
          rd_addr_d       = USED_W'(1);
        end
      end
      ubc_pkg::ACT_SCAN: begin
        // Accumulate the byte that arrived while reading the following one.
        total_d = total_q + CNT_W'(ubc_pkg::ones8(st_rd_data));
        if (open_q) begin
          run_d = run_q + CNT_W'(ubc_pkg::trailing_ones8(st_rd_data));
          if (st_rd_data != 8'hFF) begin
            open_d = 1'b0;
          end
        end
        if (rd_addr_q < used) begin
          store_ctl.rd_en = 1'b1;
          st_rd_addr      = ADDR_W'(rd_addr_q);
          rd_addr_d       = USED_W'(rd_addr_q + 1'b1);
        end else begin
          take = 1'b1;
        end
      end
      ubc_pkg::ACT_POST: begin
        if (need_set) begin
          if (run_ok) begin
            take   = 1'b1;
            pass_d = 1'b1;
          end else begin
            status_d = 1'b1;
          end
        end
      end
      ubc_pkg::ACT_RUN_RD: begin
        store_ctl.rd_en = 1'b1;
        st_rd_addr      = ADDR_W'(run_q >> 3);
      end
      ubc_pkg::ACT_RUN_WR: begin
        store_ctl.wr_en = 1'b1;
        st_wr_addr      = ADDR_W'(run_q >> 3);
        st_wr_data      = st_rd_data | (8'b1 << run_q[2:0]);
      end
      ubc_pkg::ACT_EMIT: begin
        take = !ovalid_q || out_o.ready;
        if (take) begin
          ovalid_d = 1'b1;
          ostat_d  = status_q;
          obitv_d  = bitv_q;
          orun_d   = (32'(run_q) > 32'(ubc_pkg::COUNT_MAX)) ? ubc_pkg::COUNT_MAX
                                                             : ubc_pkg::COUNT_W'(run_q);
          otot_d   = (32'(total_q) > 32'(ubc_pkg::COUNT_MAX)) ? ubc_pkg::COUNT_MAX
                                                               : ubc_pkg::COUNT_W'(total_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Step counter: fall through, branch on the take flag, or dispatch on cmd.
  always_comb begin
    case (uw.seq)
      ubc_pkg::SEQ_NEXT:     upc_d = uw.next;
      ubc_pkg::SEQ_BRANCH:   upc_d = take ? uw.jump : uw.next;
      ubc_pkg::SEQ_DISPATCH: upc_d = ubc_pkg::dispatch(cmd_q);
      default:               upc_d = ubc_pkg::UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= ubc_pkg::UPC_IDLE;
      active_q <= ubc_pkg::ACTIVE_RESET;
      ovalid_q <= 1'b0;
    end else begin
      upc_q    <= upc_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pos_q     <= pos_d;
    load_q    <= load_d;
    status_q  <= status_d;
    bitv_q    <= bitv_d;
    pass_q    <= pass_d;
    open_q    <= open_d;
    run_q     <= run_d;
    total_q   <= total_d;
    rd_addr_q <= rd_addr_d;
    ostat_q   <= ostat_d;
    obitv_q   <= obitv_d;
    orun_q    <= orun_d;
    otot_q    <= otot_d;
  end

  assign out_o.valid            = ovalid_q;
  assign out_o.status           = ostat_q;
  assign out_o.bit_value        = obitv_q;
  assign out_o.contiguous_count = orun_q;
  assign out_o.total_set        = otot_q;

`ifndef SYNTH
  // An accepted command always starts at the dispatch step.
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (upc_q == ubc_pkg::UPC_DISPATCH))
    else $error("accepted command did not reach dispatch");

  // The run from bit 0 can never exceed the number of set bits.
  a_run_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.total_set >= out_o.contiguous_count))
    else $error("contiguous count above total count");

  // A reported bit value comes only from a test that was in range.
  a_bitv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bit_value) |-> !out_o.status)
    else $error("bit value reported with out-of-range status");
`endif

endmodule

// ----- tb/sv/tb_unary_bitmap_counter.sv -----
// Self-checking testbench for the unary bitmap counter: drives command words,
// predicts every result word and compares them field by field.
// Depends on ubc_pkg, ubc_in_if, ubc_out_if and the unary_bitmap_counter RTL.
module tb_unary_bitmap_counter;

  localparam int ARRAY_BYTES     = 32;
  localparam int MAX_PAUSE       = 13;
  localparam int WORDS_PER_PHASE = 86;
  localparam int PHASES          = 11;
  localparam int IDLE_MARGIN     = 8;
  localparam int TAIL_CYCLES     = 80;
  // A grow over an alternating pattern can need one set-and-rescan pass for
  // every other bit of the array before its result word appears.
  localparam int STALL_LIMIT     = 40000;

  // The command field has one code that the block does not use.
  localparam logic [ubc_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  // Settings of active_bytes for the random phases. They cover one byte, no
  // byte at all, the full array, and values above the array that must clamp.
  localparam logic [ubc_pkg::CFG_W-1:0] PHASE_ACTIVE [PHASES] = '{
    6'd63, 6'd2, 6'd0, 6'd1, 6'd32, 6'd3, 6'd33, 6'd8, 6'd17, 6'd32, 6'd4
  };

  typedef struct packed {
    logic                        status;
    logic                        bit_value;
    logic [ubc_pkg::COUNT_W-1:0] run_len;
    logic [ubc_pkg::COUNT_W-1:0] ones;
  } counter_result_t;

  // Holds a private copy of the bit array and of active_bytes, works out the
  // result word of every accepted command and keeps the results still owed.
  class counter_scoreboard;
    bit [ubc_pkg::BYTE_W-1:0] bitmap [ARRAY_BYTES];
    bit [ubc_pkg::CFG_W-1:0]  active;
    counter_result_t          owed [$];
    int unsigned              errors;
    int unsigned              seen;

    function new();
      foreach (bitmap[i]) bitmap[i] = '0;
      active = ubc_pkg::ACTIVE_RESET;
      errors = 0;
      seen   = 0;
    endfunction

    function void set_active(input logic [ubc_pkg::CFG_W-1:0] value);
      active = value;
    endfunction

    function int unsigned bytes_in_use();
      return (active > ARRAY_BYTES) ? ARRAY_BYTES : active;
    endfunction

    function bit bit_at(input int unsigned pos);
      return bitmap[pos / ubc_pkg::BYTE_W][pos % ubc_pkg::BYTE_W];
    endfunction

    // Length of the run of ones that starts at bit 0, within the active bytes.
    function int unsigned leading_run();
      int unsigned n;
      int unsigned lim;
      n   = 0;
      lim = bytes_in_use() * ubc_pkg::BYTE_W;
      while (n < lim && bit_at(n)) n++;
      return n;
    endfunction

    function int unsigned ones_in_use();
      int unsigned sum;
      sum = 0;
      for (int unsigned i = 0; i < bytes_in_use(); i++) begin
        for (int unsigned b = 0; b < ubc_pkg::BYTE_W; b++) sum += bitmap[i][b];
      end
      return sum;
    endfunction

    function int unsigned owed_count();
      return owed.size();
    endfunction

    // Applies one accepted command to the private array and queues its result.
    function void note_command(input logic [ubc_pkg::CMD_W-1:0]  cmd,
                               input logic [ubc_pkg::POS_W-1:0]  index,
                               input logic [ubc_pkg::BYTE_W-1:0] value);
      counter_result_t r;
      int unsigned     pos;
      int unsigned     lim;
      int unsigned     run;
      int unsigned     tot;
      bit              want_odd;
      r   = '0;
      pos = index;
      lim = bytes_in_use() * ubc_pkg::BYTE_W;
      case (cmd)
        ubc_pkg::CMD_TEST: begin
          if (pos < lim) r.bit_value = bit_at(pos);
          else r.status = 1'b1;
        end
        ubc_pkg::CMD_SET, ubc_pkg::CMD_CLEAR: begin
          if (pos < lim)
            bitmap[pos / ubc_pkg::BYTE_W][pos % ubc_pkg::BYTE_W] = (cmd == ubc_pkg::CMD_SET);
          else r.status = 1'b1;
        end
        ubc_pkg::CMD_SET_NEXT: begin
          run = leading_run();
          if (run < lim) bitmap[run / ubc_pkg::BYTE_W][run % ubc_pkg::BYTE_W] = 1'b1;
          else r.status = 1'b1;
        end
        ubc_pkg::CMD_GROW_EVEN, ubc_pkg::CMD_GROW_ODD: begin
          // Keep extending the run until its length has the parity asked for.
          // Bits set before the run hits the end of the active bytes stay set.
          want_odd = (cmd == ubc_pkg::CMD_GROW_ODD);
          run = leading_run();
          while ((run % 2) != want_odd) begin
            if (run >= lim) begin
              r.status = 1'b1;
              break;
            end
            bitmap[run / ubc_pkg::BYTE_W][run % ubc_pkg::BYTE_W] = 1'b1;
            run = leading_run();
          end
        end
        ubc_pkg::CMD_LOAD: begin
          if (pos < bytes_in_use()) bitmap[pos] = value;
          else r.status = 1'b1;
        end
        default: begin
        end
      endcase
      run = leading_run();
      tot = ones_in_use();
      r.run_len = (run > ubc_pkg::COUNT_MAX) ? ubc_pkg::COUNT_MAX : ubc_pkg::COUNT_W'(run);
      r.ones    = (tot > ubc_pkg::COUNT_MAX) ? ubc_pkg::COUNT_MAX : ubc_pkg::COUNT_W'(tot);
      owed.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(input counter_result_t got);
      counter_result_t want;
      seen++;
      if (owed.size() == 0) begin
        report($sformatf("result word %0d arrived with no command pending", seen));
      end else begin
        want = owed.pop_front();
        if (got.status !== want.status)
          report($sformatf("word %0d status %b, expected %b",
                           seen, got.status, want.status));
        if (got.bit_value !== want.bit_value)
          report($sformatf("word %0d bit_value %b, expected %b",
                           seen, got.bit_value, want.bit_value));
        if (got.run_len !== want.run_len)
          report($sformatf("word %0d contiguous_count %0d, expected %0d",
                           seen, got.run_len, want.run_len));
        if (got.ones !== want.ones)
          report($sformatf("word %0d total_set %0d, expected %0d",
                           seen, got.ones, want.ones));
      end
    endtask

    task flush_leftovers();
      while (owed.size() != 0) begin
        void'(owed.pop_front());
        report("result word never arrived");
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [ubc_pkg::CFG_W-1:0]  cfg_wdata;
  bit                         calm = 1'b0;
  counter_scoreboard          sb = new();

  ubc_in_if  cmd_bus ();
  ubc_out_if res_bus ();

  unary_bitmap_counter #(
    .ARRAY_BYTES(ARRAY_BYTES)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (cmd_bus),
    .out_o      (res_bus)
  );

  always #2 clk = ~clk;

  // Pause before a word or before taking a result. In a calm phase neither
  // side holds back, so the block runs back to back.
  function automatic int unsigned pause_len();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  // Everything is sampled at the rising edge, while the testbench only
  // changes its outputs at the falling edge, so no ordering race exists.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_active(cfg_wdata);
      if (cmd_bus.valid && cmd_bus.ready)
        sb.note_command(cmd_bus.cmd, cmd_bus.bit_index, cmd_bus.load_value);
      if (res_bus.valid && res_bus.ready)
        sb.check_result('{res_bus.status, res_bus.bit_value,
                          res_bus.contiguous_count, res_bus.total_set});
    end
  end

  // Result side: before each word, hold ready low for a random number of
  // cycles, then keep it high until a word is taken.
  initial begin
    int unsigned stall;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pause_len();
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  // Watchdog: the run ends in failure when no word moves on either channel
  // for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("unary_bitmap_counter verification failed");
    $finish;
  end

  // Sends one command word. Called at a falling edge and returns at the
  // falling edge after the word was taken, with valid still high so that a
  // following word can go out without a gap.
  task automatic send_word(input logic [ubc_pkg::CMD_W-1:0]  cmd,
                           input logic [ubc_pkg::POS_W-1:0]  index,
                           input logic [ubc_pkg::BYTE_W-1:0] value);
    int unsigned gap;
    gap = pause_len();
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= cmd;
    cmd_bus.bit_index  <= index;
    cmd_bus.load_value <= value;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed result has come back, so the
  // block is idle and active_bytes may be changed.
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (sb.owed_count() != 0) @(negedge clk);
    repeat (IDLE_MARGIN) @(negedge clk);
  endtask

  task automatic write_active(input logic [ubc_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Byte values for loads. Full and alternating bytes matter most: they make
  // long runs, full runs and grow commands that need several passes.
  function automatic logic [ubc_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'hFF;
      2:       return 8'h55;
      3:       return 8'hAA;
      4:       return 8'h7F;
      5:       return 8'hFE;
      6:       return 8'h00;
      default: return ubc_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One random command word for a phase with the given number of bytes in
  // use. Most words are legal and aimed near the end of the run; a few are
  // noise over the whole field range or deliberately out of range.
  task automatic send_random(input int unsigned used);
    logic [ubc_pkg::CMD_W-1:0]  cmd;
    logic [ubc_pkg::POS_W-1:0]  index;
    logic [ubc_pkg::BYTE_W-1:0] value;
    int unsigned                lim;
    int unsigned                pick;
    lim   = used * ubc_pkg::BYTE_W;
    pick  = $urandom_range(0, 99);
    value = ubc_pkg::BYTE_W'($urandom_range(0, 255));
    index = ubc_pkg::POS_W'($urandom_range(0, (1 << ubc_pkg::POS_W) - 1));
    if (pick < 25) begin
      cmd   = ubc_pkg::CMD_LOAD;
      value = pick_byte();
      if (used != 0 && $urandom_range(0, 9) != 0)
        index = ubc_pkg::POS_W'($urandom_range(0, used - 1));
    end else if (pick < 40) begin
      cmd = ubc_pkg::CMD_SET_NEXT;
    end else if (pick < 60) begin
      cmd = $urandom_range(0, 1) ? ubc_pkg::CMD_GROW_ODD : ubc_pkg::CMD_GROW_EVEN;
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0:       cmd = ubc_pkg::CMD_SET;
        1:       cmd = ubc_pkg::CMD_CLEAR;
        default: cmd = ubc_pkg::CMD_TEST;
      endcase
      if (lim != 0) begin
        // Half of the positions fall at the start of the array, where the
        // run of ones lives, so that sets and clears open and close gaps.
        if ($urandom_range(0, 1) && lim > 24)
          index = ubc_pkg::POS_W'($urandom_range(0, 23));
        else index = ubc_pkg::POS_W'($urandom_range(0, lim - 1));
      end
    end else if (pick < 96) begin
      cmd = ubc_pkg::CMD_W'($urandom_range(0, (1 << ubc_pkg::CMD_W) - 1));
    end else begin
      cmd = $urandom_range(0, 1) ? ubc_pkg::CMD_SET : ubc_pkg::CMD_TEST;
      if (lim < (1 << ubc_pkg::POS_W))
        index = ubc_pkg::POS_W'($urandom_range(lim, (1 << ubc_pkg::POS_W) - 1));
    end
    send_word(cmd, index, value);
  endtask

  initial begin
    int unsigned used;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.cmd        = ubc_pkg::CMD_TEST;
    cmd_bus.bit_index  = '0;
    cmd_bus.load_value = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words with the reset value of active_bytes: an empty array,
    // the last bit and indexes past it, grow commands that do nothing, that
    // set one bit and that need several passes, and the unused command.
    send_word(ubc_pkg::CMD_TEST,      9'd0,   8'h00);
    send_word(ubc_pkg::CMD_SET_NEXT,  9'd0,   8'h00);
    send_word(ubc_pkg::CMD_GROW_ODD,  9'd0,   8'h00);
    send_word(ubc_pkg::CMD_GROW_EVEN, 9'd0,   8'h00);
    send_word(ubc_pkg::CMD_SET,       9'd511, 8'h00);
    send_word(ubc_pkg::CMD_SET,       9'd255, 8'h00);
    send_word(ubc_pkg::CMD_TEST,      9'd255, 8'h00);
    send_word(ubc_pkg::CMD_CLEAR,     9'd255, 8'h00);
    send_word(ubc_pkg::CMD_TEST,      9'd256, 8'h00);
    send_word(ubc_pkg::CMD_CLEAR,     9'd0,   8'h00);
    send_word(ubc_pkg::CMD_LOAD,      9'd31,  8'hFF);
    send_word(ubc_pkg::CMD_LOAD,      9'd511, 8'h00);
    send_word(ubc_pkg::CMD_LOAD,      9'd1,   8'h7F);
    send_word(ubc_pkg::CMD_LOAD,      9'd0,   8'hFF);
    send_word(ubc_pkg::CMD_GROW_EVEN, 9'd0,   8'h00);
    send_word(ubc_pkg::CMD_LOAD,      9'd2,   8'hAA);
    send_word(ubc_pkg::CMD_GROW_ODD,  9'd0,   8'h00);
    send_word(CMD_UNUSED,             9'd511, 8'hFF);
    settle();

    // One active byte: a grow that fills the byte, then a full run for set
    // next and for a grow of the wrong parity. Byte 31 still holds ones but
    // is inactive, so it must not show up in the counts.
    write_active(6'd1);
    send_word(ubc_pkg::CMD_LOAD,      9'd0,   8'h7F);
    send_word(ubc_pkg::CMD_GROW_EVEN, 9'd0,   8'h00);
    send_word(ubc_pkg::CMD_SET_NEXT,  9'd0,   8'h00);
    send_word(ubc_pkg::CMD_GROW_ODD,  9'd0,   8'h00);
    send_word(ubc_pkg::CMD_LOAD,      9'd1,   8'h55);
    send_word(ubc_pkg::CMD_TEST,      9'd8,   8'h00);
    settle();

    // No active byte: everything is out of range and both counts are zero.
    write_active(6'd0);
    send_word(ubc_pkg::CMD_TEST,      9'd0,   8'h00);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_active(PHASE_ACTIVE[p]);
      used = (PHASE_ACTIVE[p] > ARRAY_BYTES) ? ARRAY_BYTES : PHASE_ACTIVE[p];
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_random(used);
      settle();
    end

    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("unary_bitmap_counter verification clean");
    end else begin
      $display("unary_bitmap_counter verification failed");
    end
    $finish;
  end

endmodule
